// ----- rtl/fixed_block_free_list_allocator_core_assert.svh -----
// Assertion macros for the free-list allocator core.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define FBFL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator core assertion failed");
// next-cycle implication
`define FBFL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator core assertion failed");
`else
`define FBFL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FBFL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/fbfl_pkg.sv -----
// Shared types and constants of the free-list allocator.
`timescale 1ns / 1ps
package fbfl_pkg;

    localparam int NUM_BLOCKS_DEF = 256;

    localparam int FUNC_W   = 1;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 9'd256;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic start_clear;  // block count written, restart relink sweep
        logic clear_step;   // relink one link entry
        logic capture_req;  // request word accepted
        logic commit;       // update head/link and load result register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;   // sweep is at the last entry
    } dp_stat_t;

endpackage

// ----- rtl/fbfl_if.sv -----
// Valid/ready channel interfaces: request, response and configuration.
`timescale 1ns / 1ps
interface fbfl_req_if;
    logic                        valid;
    logic                        ready;
    logic [fbfl_pkg::FUNC_W-1:0] func;
    logic [fbfl_pkg::INDEX_W-1:0] block_index;

    modport source (output valid, output func, output block_index, input ready);
    modport sink (input valid, input func, input block_index, output ready);
endinterface

interface fbfl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fbfl_pkg::INDEX_W-1:0]  granted_index;
    logic [fbfl_pkg::STATUS_W-1:0] status;
    logic                          heap_empty;

    modport source (output valid, output granted_index, output status,
                    output heap_empty, input ready);
    modport sink (input valid, input granted_index, input status,
                  input heap_empty, output ready);
endinterface

interface fbfl_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [fbfl_pkg::COUNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/fbfl_ctrl.sv -----
// Sequencing state machine of the free-list allocator.
`timescale 1ns / 1ps
module fbfl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic                  cfg_valid,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  fbfl_pkg::dp_stat_t    stat,
    output fbfl_pkg::ctrl_cmd_t   cmd
);
    import fbfl_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && !cfg_valid;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next       = state_reg;
        cmd              = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = !cfg_valid;
                if (stat.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    cmd.capture_req = 1'b1;
                    state_next      = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold while the previous result is still waiting
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        // a block count write always restarts the relink sweep
        if (cfg_valid)
        begin
            cmd.start_clear = 1'b1;
            state_next      = ST_CLEAR;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- rtl/fbfl_dp.sv -----
// Datapath: head register, link memory, block count and result register.
`timescale 1ns / 1ps
module fbfl_dp #(
    parameter int NUM_BLOCKS = fbfl_pkg::NUM_BLOCKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fbfl_pkg::ctrl_cmd_t             cmd,
    output fbfl_pkg::dp_stat_t              stat,
    input  logic [fbfl_pkg::COUNT_W-1:0]    cfg_data,
    input  logic [fbfl_pkg::FUNC_W-1:0]     req_func,
    input  logic [fbfl_pkg::INDEX_W-1:0]    req_index,
    output logic [fbfl_pkg::INDEX_W-1:0]    granted_index,
    output logic [fbfl_pkg::STATUS_W-1:0]   status,
    output logic                            heap_empty
);
    import fbfl_pkg::*;

    localparam int LW = $clog2(NUM_BLOCKS + 1);        // link width, holds end mark
    localparam int IW = $clog2(NUM_BLOCKS);            // memory address width
    localparam int CW = (LW > COUNT_W) ? LW : COUNT_W; // compare width
    localparam logic [LW-1:0] LIST_END = LW'(NUM_BLOCKS);
    localparam logic [CW-1:0] MAX_COUNT = CW'(NUM_BLOCKS);
    localparam logic [IW-1:0] LAST_ADDR = IW'(NUM_BLOCKS - 1);

    logic [LW-1:0] link_mem [NUM_BLOCKS];
    logic [LW-1:0] rd_data_reg;

    logic [COUNT_W-1:0]  count_reg;
    logic [LW-1:0]       head_reg, head_next;
    logic [IW-1:0]       clr_cnt_reg;
    logic [FUNC_W-1:0]   func_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [INDEX_W-1:0]  granted_reg, granted_next;
    status_t             status_reg, status_next;
    logic                empty_reg;

    logic [CW-1:0] eff_count;
    logic [CW-1:0] clr_succ;
    logic          head_is_end;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [LW-1:0] mem_wd;

    always_comb
    begin
        if (CW'(count_reg) > MAX_COUNT)
            eff_count = MAX_COUNT;
        else
            eff_count = CW'(count_reg);
    end

    assign clr_succ        = CW'(clr_cnt_reg) + CW'(1);
    assign head_is_end     = head_reg >= LIST_END;
    assign stat.clear_last = clr_cnt_reg == LAST_ADDR;

    always_comb
    begin
        head_next    = head_reg;
        granted_next = '0;
        status_next  = STATUS_DONE;
        mem_we       = 1'b0;
        mem_wa       = IW'(index_reg);
        mem_wd       = head_reg;
        if (cmd.clear_step)
        begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_reg;
            mem_wd = (clr_succ < eff_count) ? LW'(clr_succ) : LIST_END;
            head_next = (eff_count == '0) ? LIST_END : '0;
        end
        else if (cmd.commit)
        begin
            if (func_reg == FUNC_ALLOC)
            begin
                if (head_is_end)
                    status_next = STATUS_EMPTY;
                else
                begin
                    granted_next = INDEX_W'(head_reg);
                    head_next    = rd_data_reg;
                end
            end
            else
            begin
                if (CW'(index_reg) >= eff_count)
                    status_next = STATUS_RANGE;
                else
                begin
                    mem_we    = 1'b1;
                    head_next = LW'(index_reg);
                end
            end
        end
    end

    // link memory; the read port always follows the head
    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[mem_wa] <= mem_wd;
        rd_data_reg <= link_mem[head_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= BLOCK_COUNT_RST;
            head_reg    <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            if (cmd.start_clear)
            begin
                count_reg   <= cfg_data;
                clr_cnt_reg <= '0;
            end
            else if (cmd.clear_step)
                clr_cnt_reg <= clr_cnt_reg + IW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture_req)
        begin
            func_reg  <= req_func;
            index_reg <= req_index;
        end
        if (cmd.commit)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
            empty_reg   <= head_next >= LIST_END;
        end
    end

    assign granted_index = granted_reg;
    assign status        = status_reg;
    assign heap_empty    = empty_reg;

endmodule

// ----- rtl/fixed_block_free_list_allocator_core.sv -----
// Top level of the fixed-size block free-list allocator.
//
//  channel  dir  handshake    word
//  req      in   valid/ready  func, block_index
//  rsp      out  valid/ready  granted_index, status, heap_empty
//  cfg      in   valid/ready  data (block_count)
//
// Each request is accepted, then committed with the registered link memory read.
// After reset and after each cfg write the links are relinked by a sweep of all NUM_BLOCKS
// entries, one a cycle while cfg is idle; req is not taken meanwhile, cfg is always taken.
// A result waits in the output register while the next request is accepted; the commit
// of that request stalls until the waiting result is taken.
`timescale 1ns / 1ps
`include "fixed_block_free_list_allocator_core_assert.svh"
module fixed_block_free_list_allocator_core #(
    parameter int NUM_BLOCKS = fbfl_pkg::NUM_BLOCKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fbfl_req_if.sink    req,
    fbfl_rsp_if.source  rsp,
    fbfl_cfg_if.sink    cfg
);
    import fbfl_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg.ready = 1'b1;

    fbfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .cfg_valid (cfg.valid),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fbfl_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_data      (cfg.data),
        .req_func      (req.func),
        .req_index     (req.block_index),
        .granted_index (rsp.granted_index),
        .status        (rsp.status),
        .heap_empty    (rsp.heap_empty)
    );

    // one request in flight at a time
    `FBFL_ASSERT_NXT(a_one_in_flight, clk, rst_n, req.valid && req.ready, !req.ready)
    // a block count write starts the relink sweep
    `FBFL_ASSERT_NXT(a_cfg_relinks, clk, rst_n, cfg.valid && cfg.ready, !req.ready)
    // a commit never overwrites a result still waiting
    `FBFL_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.commit, !rsp.valid || rsp.ready)
    // a commit always presents a result next cycle
    `FBFL_ASSERT_NXT(a_commit_out, clk, rst_n, cmd.commit, rsp.valid)

endmodule

// ----- verif/fixed_block_free_list_allocator_core_tb.sv -----
// Self-checking testbench of the free-list allocator core: directed table, then random phases.
`timescale 1ns / 1ps
module fixed_block_free_list_allocator_core_tb;
    import fbfl_pkg::*;

    localparam logic [COUNT_W-1:0] LIST_END = COUNT_W'(NUM_BLOCKS_DEF);
    localparam int NUM_PHASES = 10;
    localparam int PHASE_ITEMS = 150;
    localparam int NUM_ROWS = 25;

    typedef struct packed {
        logic [INDEX_W-1:0] granted;
        status_t            status;
        logic               empty;
    } alloc_word_t;

    typedef struct packed {
        bit                 is_cfg;
        logic [COUNT_W-1:0] cfg_value;
        logic               func;
        logic [INDEX_W-1:0] idx;
        bit                 typed;
        alloc_word_t        want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    fbfl_req_if req_ch ();
    fbfl_rsp_if rsp_ch ();
    fbfl_cfg_if cfg_ch ();

    fixed_block_free_list_allocator_core #(
        .NUM_BLOCKS (NUM_BLOCKS_DEF)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // allocator state as predicted
    logic [COUNT_W-1:0] block_count_reg;
    logic [COUNT_W-1:0] free_head;
    logic [COUNT_W-1:0] free_next [NUM_BLOCKS_DEF];

    alloc_word_t        expected_words [$];
    logic [INDEX_W-1:0] held_blocks [$];
    int unsigned        error_count = 0;
    int unsigned        req_calm = 0;
    int unsigned        rsp_calm = 0;
    int unsigned        rsp_stall = 0;
    alloc_word_t        seen_word;
    alloc_word_t        due_word;
    stim_row_t          directed_rows [NUM_ROWS];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned usable_blocks();
        return (block_count_reg > LIST_END) ? NUM_BLOCKS_DEF : int'(block_count_reg);
    endfunction

    task automatic relink_model();
        int unsigned n;
        n = usable_blocks();
        for (int i = 0; i < NUM_BLOCKS_DEF; i++)
        begin
            free_next[i] = (i + 1 < n) ? COUNT_W'(i + 1) : LIST_END;
        end
        free_head = (n == 0) ? LIST_END : '0;
        held_blocks.delete();
    endtask

    task automatic predict_word(input logic f, input logic [INDEX_W-1:0] idx,
                                output alloc_word_t w);
        w.granted = '0;
        w.status  = STATUS_DONE;
        if (f == FUNC_ALLOC)
        begin
            if (free_head >= LIST_END)
                w.status = STATUS_EMPTY;
            else
            begin
                w.granted = free_head[INDEX_W-1:0];
                held_blocks.push_back(free_head[INDEX_W-1:0]);
                free_head = free_next[free_head[INDEX_W-1:0]];
            end
        end
        else if (idx >= usable_blocks())
            w.status = STATUS_RANGE;
        else
        begin
            // unchecked push: a double release may close the list into a loop
            free_next[idx] = free_head;
            free_head      = {1'b0, idx};
        end
        w.empty = (free_head >= LIST_END);
    endtask

    // mostly short gaps, a few long ones, and now and then a calm stretch
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned exp_v,
                                   input int unsigned got_v);
        error_count++;
        if (error_count <= 40)
            $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
    endtask

    task automatic send_request(input logic f, input logic [INDEX_W-1:0] idx,
                                input bit typed, input alloc_word_t want);
        int unsigned gap;
        alloc_word_t predicted;
        gap = pick_gap(req_calm);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= f;
        req_ch.block_index <= idx;
        do
            @(negedge clk);
        while (!req_ch.ready);
        @(posedge clk);
        predict_word(f, idx, predicted);
        expected_words.push_back(typed ? want : predicted);
    endtask

    // only written with no word in flight
    task automatic write_count(input logic [COUNT_W-1:0] v);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
            @(negedge clk);
        while (!cfg_ch.ready);
        @(posedge clk);
        cfg_ch.valid    <= 1'b0;
        block_count_reg = v;
        relink_model();
    endtask

    // receiver stalls
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    rsp_stall = pick_gap(rsp_calm);
            end
        end
    end

    // handshake values are stable from the falling edge to the next rising edge
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            seen_word.granted = rsp_ch.granted_index;
            seen_word.status  = status_t'(rsp_ch.status);
            seen_word.empty   = rsp_ch.heap_empty;
            if (expected_words.size() == 0)
                report_mismatch("unexpected word, granted", 0, 32'(seen_word.granted));
            else
            begin
                due_word = expected_words.pop_front();
                if (seen_word.granted !== due_word.granted)
                    report_mismatch("granted_index", 32'(due_word.granted),
                                    32'(seen_word.granted));
                if (seen_word.status !== due_word.status)
                    report_mismatch("status", 32'(due_word.status), 32'(seen_word.status));
                if (seen_word.empty !== due_word.empty)
                    report_mismatch("heap_empty", 32'(due_word.empty), 32'(seen_word.empty));
            end
        end
    end

    initial
    begin
        int unsigned        phase_counts [NUM_PHASES];
        int unsigned        alloc_bias;
        int unsigned        pick;
        logic               f;
        logic [INDEX_W-1:0] idx;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.func        = FUNC_ALLOC;
        req_ch.block_index = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = BLOCK_COUNT_RST;

        // typed expectations only where the answer is plain; the rest go to the predictor
        directed_rows = '{
            '{1'b0, 9'd0,   FUNC_ALLOC,   8'd0,   1'b1, '{8'd0,   STATUS_DONE,  1'b0}},
            '{1'b0, 9'd0,   FUNC_ALLOC,   8'd0,   1'b1, '{8'd1,   STATUS_DONE,  1'b0}},
            '{1'b0, 9'd0,   FUNC_RELEASE, 8'd255, 1'b1, '{8'd0,   STATUS_DONE,  1'b0}},
            '{1'b0, 9'd0,   FUNC_ALLOC,   8'd0,   1'b1, '{8'd255, STATUS_DONE,  1'b0}},
            '{1'b0, 9'd0,   FUNC_RELEASE, 8'd0,   1'b1, '{8'd0,   STATUS_DONE,  1'b0}},
            '{1'b0, 9'd0,   FUNC_RELEASE, 8'd0,   1'b0, '{8'd0,   STATUS_DONE,  1'b0}},
            '{1'b0, 9'd0,   FUNC_ALLOC,   8'd0,   1'b0, '{8'd0,   STATUS_DONE,  1'b0}},
            '{1'b0, 9'd0,   FUNC_ALLOC,   8'd0,   1'b0, '{8'd0,   STATUS_DONE,  1'b0}},
            '{1'b1, 9'd1,   FUNC_ALLOC,   8'd0,   1'b0, '{8'd0,   STATUS_DONE,  1'b0}},
            '{1'b0, 9'd0,   FUNC_ALLOC,   8'd0,   1'b1, '{8'd0,   STATUS_DONE,  1'b1}},
            '{1'b0, 9'd0,   FUNC_ALLOC,   8'd0,   1'b1, '{8'd0,   STATUS_EMPTY, 1'b1}},
            '{1'b0, 9'd0,   FUNC_RELEASE, 8'd1,   1'b1, '{8'd0,   STATUS_RANGE, 1'b1}},
            '{1'b0, 9'd0,   FUNC_RELEASE, 8'd0,   1'b0, '{8'd0,   STATUS_DONE,  1'b0}},
            '{1'b0, 9'd0,   FUNC_RELEASE, 8'd255, 1'b1, '{8'd0,   STATUS_RANGE, 1'b0}},
            '{1'b1, 9'd0,   FUNC_ALLOC,   8'd0,   1'b0, '{8'd0,   STATUS_DONE,  1'b0}},
            '{1'b0, 9'd0,   FUNC_ALLOC,   8'd0,   1'b1, '{8'd0,   STATUS_EMPTY, 1'b1}},
            '{1'b0, 9'd0,   FUNC_RELEASE, 8'd0,   1'b1, '{8'd0,   STATUS_RANGE, 1'b1}},
            '{1'b1, 9'd511, FUNC_ALLOC,   8'd0,   1'b0, '{8'd0,   STATUS_DONE,  1'b0}},
            '{1'b0, 9'd0,   FUNC_RELEASE, 8'd255, 1'b0, '{8'd0,   STATUS_DONE,  1'b0}},
            '{1'b0, 9'd0,   FUNC_ALLOC,   8'd0,   1'b0, '{8'd0,   STATUS_DONE,  1'b0}},
            '{1'b0, 9'd0,   FUNC_ALLOC,   8'd0,   1'b0, '{8'd0,   STATUS_DONE,  1'b0}},
            '{1'b1, 9'd2,   FUNC_ALLOC,   8'd0,   1'b0, '{8'd0,   STATUS_DONE,  1'b0}},
            '{1'b0, 9'd0,   FUNC_RELEASE, 8'd1,   1'b0, '{8'd0,   STATUS_DONE,  1'b0}},
            '{1'b0, 9'd0,   FUNC_ALLOC,   8'd0,   1'b0, '{8'd0,   STATUS_DONE,  1'b0}},
            '{1'b0, 9'd0,   FUNC_ALLOC,   8'd0,   1'b0, '{8'd0,   STATUS_DONE,  1'b0}}
        };

        phase_counts = '{256, 300, 1, 2, 0, 511, 257,
                         $urandom_range(3, 16), $urandom_range(3, 16), $urandom_range(1, 256)};

        block_count_reg = BLOCK_COUNT_RST;
        relink_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_cfg)
                write_count(directed_rows[r].cfg_value);
            else
                send_request(directed_rows[r].func, directed_rows[r].idx,
                             directed_rows[r].typed, directed_rows[r].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_count(COUNT_W'(phase_counts[p]));
            alloc_bias = $urandom_range(35, 70);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                idx  = INDEX_W'($urandom_range(0, 255));
                if (pick < 12)
                    f = 1'($urandom_range(0, 1));  // noise: random alloc, or stray or repeated release
                else if (held_blocks.size() > 0 && $urandom_range(0, 99) >= alloc_bias)
                begin
                    pick = $urandom_range(0, held_blocks.size() - 1);
                    idx  = held_blocks[pick];
                    held_blocks.delete(pick);
                    f = FUNC_RELEASE;
                end
                else
                    f = FUNC_ALLOC;
                send_request(f, idx, 1'b0, '0);
            end
        end

        req_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- fixed_block_free_list_allocator_core.f -----
+incdir+rtl
rtl/fbfl_pkg.sv
rtl/fbfl_if.sv
rtl/fbfl_ctrl.sv
rtl/fbfl_dp.sv
rtl/fixed_block_free_list_allocator_core.sv
verif/fixed_block_free_list_allocator_core_tb.sv
